>>> src/dssc_pkg.sv
package dssc_pkg;

  // field widths
  localparam int unsigned AngleWidth    = 8;
  localparam int unsigned PulseWidth    = 12;
  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned IntervalWidth = 16;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned CfgIndexWidth = 3;

  typedef logic [AngleWidth-1:0]    angle_t;
  typedef logic [PulseWidth-1:0]    pulse_t;
  typedef logic [TimeWidth-1:0]     time_ms_t;
  typedef logic [IntervalWidth-1:0] interval_t;

  // angle and pulse limits
  localparam angle_t AngleMax   = 8'd180;
  localparam pulse_t PulseMinUs = 12'd500;
  localparam pulse_t PulseMaxUs = 12'd2500;

  // 2000/180 scaled by 2^16, rounded up; exact floor for angles 0..180
  localparam int unsigned PulseRecipShift = 16;
  localparam int unsigned PulseRecipWidth = 20;
  localparam logic [PulseRecipWidth-1:0] PulseRecip = 20'd728178;

  // register reset values
  localparam angle_t    HomeAngleReset = 8'd90;
  localparam angle_t    UpAngleAReset  = 8'd35;
  localparam angle_t    UpAngleBReset  = 8'd145;
  localparam angle_t    DownAngleAReset = 8'd145;
  localparam angle_t    DownAngleBReset = 8'd35;
  localparam interval_t IntervalReset  = 16'd20;

  // register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_HOME_ANGLE_A    = 3'd0,
    REG_HOME_ANGLE_B    = 3'd1,
    REG_UP_ANGLE_A      = 3'd2,
    REG_UP_ANGLE_B      = 3'd3,
    REG_DOWN_ANGLE_A    = 3'd4,
    REG_DOWN_ANGLE_B    = 3'd5,
    REG_STEP_INTERVAL   = 3'd6
  } cfg_index_t;

endpackage

>>> src/dssc_sample_if.sv
interface dssc_sample_if;
  logic                 valid;
  logic                 ready;
  logic                 up_pressed;
  logic                 down_pressed;
  dssc_pkg::time_ms_t   now_ms;

  modport source (output valid, output up_pressed, output down_pressed, output now_ms,
                  input ready);
  modport sink (input valid, input up_pressed, input down_pressed, input now_ms,
                output ready);
endinterface

>>> src/dssc_result_if.sv
interface dssc_result_if;
  logic             valid;
  logic             ready;
  dssc_pkg::angle_t angle_a;
  dssc_pkg::angle_t angle_b;
  dssc_pkg::pulse_t pulse_a_us;
  dssc_pkg::pulse_t pulse_b_us;

  modport source (output valid, output angle_a, output angle_b, output pulse_a_us,
                  output pulse_b_us, input ready);
  modport sink (input valid, input angle_a, input angle_b, input pulse_a_us,
                input pulse_b_us, output ready);
endinterface

>>> src/dssc_pulse.sv
module dssc_pulse (
  input  dssc_pkg::angle_t angle,
  output dssc_pkg::pulse_t pulse_us
);

  localparam int unsigned ProdWidth = dssc_pkg::AngleWidth + dssc_pkg::PulseRecipWidth;

  logic [ProdWidth-1:0] prod;

  // angle * 2000 / 180 by reciprocal multiply
  assign prod = ProdWidth'(angle) * ProdWidth'(dssc_pkg::PulseRecip);
  assign pulse_us = dssc_pkg::PulseMinUs
                  + prod[dssc_pkg::PulseRecipShift +: dssc_pkg::PulseWidth];

endmodule

>>> src/dual_servo_slew_controller.sv
// Dual servo slew-rate controller.
// sample channel: one transaction per button sample (up and down levels plus a
//   free-running millisecond timestamp); targets follow button presses.
// result channel: a transaction only when a one-degree step is due, carrying
//   both angles and their pulse widths in microseconds.
// cfg_we/cfg_index/cfg_data: register writes, taken on any edge with cfg_we
//   high; angle writes saturate at 180 degrees. Write only while idle.
// Flow: a sample is taken into the input register, then processed into the result
//   register, from which its result is offered. Throughput: one sample per cycle
//   while result.ready does not hold back a pending result, set by the single
//   input register and single result register around the state update.
// Reset (rst, synchronous): registers return to their defaults, both angles
//   and targets to 90 degrees, last step time to zero, no result pending.
// Stall: while a result waits on result.ready the input register can still
//   take one sample; the next sample waits until the result is taken.
module dual_servo_slew_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  dssc_sample_if.sink                           sample,
  dssc_result_if.source                         result,
  input  logic                                  cfg_we,
  input  logic [dssc_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [dssc_pkg::CfgDataWidth-1:0]     cfg_data
);

  // configuration registers
  dssc_pkg::angle_t    home_angle_a, home_angle_b;
  dssc_pkg::angle_t    up_angle_a, up_angle_b;
  dssc_pkg::angle_t    down_angle_a, down_angle_b;
  dssc_pkg::interval_t step_interval_ms;

  // servo state
  dssc_pkg::angle_t    current_a, current_b, target_a, target_b;
  dssc_pkg::angle_t    current_a_next, current_b_next, target_a_next, target_b_next;
  dssc_pkg::time_ms_t  last_step_time;
  logic                prev_up, prev_down;

  // input register
  logic                s0_valid;
  logic                s0_up, s0_down;
  dssc_pkg::time_ms_t  s0_now;

  // result register
  logic                out_valid;
  dssc_pkg::angle_t    out_angle_a, out_angle_b;
  dssc_pkg::pulse_t    out_pulse_a, out_pulse_b;
  dssc_pkg::pulse_t    pulse_a_next, pulse_b_next;

  logic                advance;
  logic                step_due;
  dssc_pkg::angle_t    cfg_angle;
  dssc_pkg::time_ms_t  elapsed;

  function automatic dssc_pkg::angle_t move_one(dssc_pkg::angle_t cur, dssc_pkg::angle_t tgt);
    if (cur < tgt) begin
      return cur + 8'd1;
    end else if (cur > tgt) begin
      return cur - 8'd1;
    end
    return cur;
  endfunction

  // handshake
  assign advance      = !out_valid || result.ready;
  assign sample.ready = !s0_valid || advance;

  // saturated angle from write data
  assign cfg_angle = (cfg_data[dssc_pkg::AngleWidth-1:0] > dssc_pkg::AngleMax)
                   ? dssc_pkg::AngleMax : cfg_data[dssc_pkg::AngleWidth-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      home_angle_a     <= dssc_pkg::HomeAngleReset;
      home_angle_b     <= dssc_pkg::HomeAngleReset;
      up_angle_a       <= dssc_pkg::UpAngleAReset;
      up_angle_b       <= dssc_pkg::UpAngleBReset;
      down_angle_a     <= dssc_pkg::DownAngleAReset;
      down_angle_b     <= dssc_pkg::DownAngleBReset;
      step_interval_ms <= dssc_pkg::IntervalReset;
    end else if (cfg_we) begin
      case (cfg_index)
        dssc_pkg::REG_HOME_ANGLE_A:  home_angle_a     <= cfg_angle;
        dssc_pkg::REG_HOME_ANGLE_B:  home_angle_b     <= cfg_angle;
        dssc_pkg::REG_UP_ANGLE_A:    up_angle_a       <= cfg_angle;
        dssc_pkg::REG_UP_ANGLE_B:    up_angle_b       <= cfg_angle;
        dssc_pkg::REG_DOWN_ANGLE_A:  down_angle_a     <= cfg_angle;
        dssc_pkg::REG_DOWN_ANGLE_B:  down_angle_b     <= cfg_angle;
        dssc_pkg::REG_STEP_INTERVAL: step_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (sample.ready) begin
      s0_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      s0_up   <= sample.up_pressed;
      s0_down <= sample.down_pressed;
      s0_now  <= sample.now_ms;
    end
  end

  // target selection and step decision
  always_comb begin
    target_a_next = target_a;
    target_b_next = target_b;
    if (s0_up && s0_down) begin
      target_a_next = home_angle_a;
      target_b_next = home_angle_b;
    end else if (s0_up && !prev_up) begin
      target_a_next = up_angle_a;
      target_b_next = up_angle_b;
    end else if (s0_down && !prev_down) begin
      target_a_next = down_angle_a;
      target_b_next = down_angle_b;
    end
    elapsed        = s0_now - last_step_time;
    step_due       = elapsed >= dssc_pkg::TimeWidth'(step_interval_ms);
    current_a_next = move_one(current_a, target_a_next);
    current_b_next = move_one(current_b, target_b_next);
  end

  // pulse widths of the stepped angles
  dssc_pulse u_pulse_a (.angle(current_a_next), .pulse_us(pulse_a_next));
  dssc_pulse u_pulse_b (.angle(current_b_next), .pulse_us(pulse_b_next));

  // servo state update
  always_ff @(posedge clk) begin
    if (rst) begin
      current_a      <= dssc_pkg::HomeAngleReset;
      current_b      <= dssc_pkg::HomeAngleReset;
      target_a       <= dssc_pkg::HomeAngleReset;
      target_b       <= dssc_pkg::HomeAngleReset;
      last_step_time <= '0;
      prev_up        <= 1'b0;
      prev_down      <= 1'b0;
    end else if (s0_valid && advance) begin
      target_a  <= target_a_next;
      target_b  <= target_b_next;
      prev_up   <= s0_up;
      prev_down <= s0_down;
      if (step_due) begin
        last_step_time <= s0_now;
        current_a      <= current_a_next;
        current_b      <= current_b_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s0_valid && step_due;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s0_valid && step_due) begin
      out_angle_a <= current_a_next;
      out_angle_b <= current_b_next;
      out_pulse_a <= pulse_a_next;
      out_pulse_b <= pulse_b_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.angle_a    = out_angle_a;
  assign result.angle_b    = out_angle_b;
  assign result.pulse_a_us = out_pulse_a;
  assign result.pulse_b_us = out_pulse_b;

  // a pending result always shows the present servo angles
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_angle_a == current_a && out_angle_b == current_b))
    else $error("pending result differs from servo state");

  // servo A angle moves by at most one degree a cycle
  a_slew_limited: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (current_a == $past(current_a) || current_a == $past(current_a) + 8'd1
                     || current_a == $past(current_a) - 8'd1))
    else $error("servo A angle jumped");

  // targets and angles stay in range
  a_angles_in_range: assert property (@(posedge clk) disable iff (rst)
    target_a <= dssc_pkg::AngleMax && target_b <= dssc_pkg::AngleMax
    && current_a <= dssc_pkg::AngleMax && current_b <= dssc_pkg::AngleMax)
    else $error("angle out of range");

  // pulses stay within the servo window
  a_pulse_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_pulse_a >= dssc_pkg::PulseMinUs && out_pulse_a <= dssc_pkg::PulseMaxUs
                   && out_pulse_b >= dssc_pkg::PulseMinUs
                   && out_pulse_b <= dssc_pkg::PulseMaxUs))
    else $error("pulse width out of range");

endmodule
